FILE: design/fat_cluster_chain_walker_top_defines.svh
// Assertion macros for the FAT cluster chain walker.
// Needs clk_i and rst_ni in the scope where a macro is used.
// Synthesis builds define SYNTHESIS and get empty bodies.
`ifndef FAT_CLUSTER_CHAIN_WALKER_TOP_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_WALKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset
`define FCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define FCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FCW_ASSERT_NOW(lbl, ante, cons, msg)
`define FCW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/fcw_pkg.sv
// Shared types, codes and table-entry helpers for the FAT cluster chain walker.
// No dependencies; imported by the top level, the walker and the testbench.
`default_nettype none

package fcw_pkg;

  // Entry width selected by the configuration register (code three acts as FAT32)
  typedef enum logic [1:0] {
    FCW_FAT12 = 2'd0,
    FCW_FAT16 = 2'd1,
    FCW_FAT32 = 2'd2
  } fcw_mode_e;

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_WALK = 1'b1;

  // End-of-chain thresholds
  localparam logic [27:0] FCW_END12 = 28'h0000ff8;
  localparam logic [27:0] FCW_END16 = 28'h000fff8;
  localparam logic [27:0] FCW_END32 = 28'hffffff8;

  typedef struct packed {
    logic        func;
    logic [14:0] load_index;
    logic [15:0] load_word;
    logic [27:0] start_cluster;
    logic [15:0] hop_count;
  } fcw_in_t;

  typedef struct packed {
    logic [31:0] reached_cluster;
    logic        chain_ended;
    logic [15:0] hops_done;
    logic        out_of_range;
  } fcw_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_RD0,
    ST_RD1
  } fcw_state_e;

  // Assemble the entry from the low and high words read from the table
  function automatic logic [27:0] fcw_entry(logic [1:0] mode, logic n_odd, logic b_odd,
                                            logic [15:0] lo, logic [15:0] hi);
    logic [15:0] pair;
    logic [27:0] v;
    pair = b_odd ? {hi[7:0], lo[15:8]} : lo;
    unique case (mode)
      FCW_FAT12: v = n_odd ? 28'(pair[15:4]) : 28'(pair[11:0]);
      FCW_FAT16: v = 28'(lo);
      default:   v = {hi[11:0], lo};
    endcase
    return v;
  endfunction

  // Free entry or end marker for the given width
  function automatic logic fcw_stop(logic [1:0] mode, logic [27:0] v);
    logic past_end;
    unique case (mode)
      FCW_FAT12: past_end = (v >= FCW_END12);
      FCW_FAT16: past_end = (v >= FCW_END16);
      default:   past_end = (v >= FCW_END32);
    endcase
    return past_end || (v == 28'd0);
  endfunction

endpackage

`default_nettype wire

FILE: design/fat_cluster_chain_walker_top.sv
// FAT cluster chain walker: top level with configuration register and load write path.
// Depends on fcw_pkg, fcw_table_mem, fcw_walker and the assertion macro header.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. A load item
//   (func 0) writes load_word at load_index; indexes beyond the store are dropped.
//   A walk item (func 1) follows hop_count links from start_cluster.
//   Every item gives exactly one result, shown on result_o for one cycle while
//   result_strobe_o is high. The receiver has no way to hold a result off.
//   A load, or a walk of zero hops, strobes its result in the cycle after
//   acceptance, and busy stays low, so one item per cycle goes in.
//   A walk keeps busy high through the states LOOK and RD0 for each hop when the
//   entry sits in one word (FAT16, FAT12 with an even byte offset), and through
//   LOOK, RD0 and RD1 when it spans two words (FAT32, FAT12 with an odd byte offset);
//   the single table read port sets this. The result strobes in the cycle busy falls.
//   Loads and walks never overlap, so no read meets a pending write.
//   The user must write fat_width_mode through cfg_we_i only while the block is idle;
//   the block itself does not enforce this. Reset clears the mode to FAT12 and the
//   sequencer to idle; table contents stay undefined until loaded.
`default_nettype none
`include "fat_cluster_chain_walker_top_defines.svh"

module fat_cluster_chain_walker_top import fcw_pkg::*; #(
  parameter int unsigned FAT_WORDS = 32768
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  fcw_in_t    item_i,
  output logic       result_strobe_o,
  output fcw_out_t   result_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(FAT_WORDS);
  localparam logic [22:0] WordsLim = 23'(FAT_WORDS);

  logic [1:0]    mode_q;
  logic          accept;
  logic          mem_we;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;

  // Width mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= FCW_FAT12;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Load transfer writes one word when it lands inside the store
  assign accept = start && !busy;
  assign mem_we = accept && (item_i.func == FUNC_LOAD) &&
                  (23'(item_i.load_index) < WordsLim);

  fcw_table_mem #(
    .Words(FAT_WORDS)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (mem_we),
    .wr_addr_i(AW'(item_i.load_index)),
    .wr_data_i(item_i.load_word),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  fcw_walker #(
    .Words(FAT_WORDS)
  ) u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .accept_i       (accept),
    .item_i         (item_i),
    .busy_o         (busy),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

  // A finished walk strobes its result as busy drops
  `FCW_ASSERT_NOW(a_done_strobe, $fell(busy), result_strobe_o, "walk ended without result")
  // A load transfer answers next cycle with an all-zero result
  `FCW_ASSERT_NEXT(a_load_result, accept && (item_i.func == FUNC_LOAD),
                   result_strobe_o && (result_o == '0), "load result missing or nonzero")
  // Table writes and walk reads never share a cycle
  `FCW_ASSERT_NOW(a_no_rw_clash, mem_we, !rd_en, "write during walk read")

endmodule

`default_nettype wire

FILE: design/fcw_table_mem.sv
// Single-port-write, single-port-read table store with a registered read.
// Depends on nothing but its parameter.
`default_nettype none

module fcw_table_mem #(
  parameter int unsigned Words = 32768,
  localparam int unsigned AW = $clog2(Words)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [15:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [15:0]   rd_data_o
);

  logic [15:0] mem [Words];
  logic [15:0] rd_data_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: design/fcw_walker.sv
// Chain-walk sequencer: address generation, table reads, entry decode and result register.
// Depends on fcw_pkg; drives the read port of fcw_table_mem.
`default_nettype none

module fcw_walker import fcw_pkg::*; #(
  parameter int unsigned Words = 32768,
  localparam int unsigned AW = $clog2(Words)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    mode_i,
  input  logic          accept_i,
  input  fcw_in_t       item_i,
  output logic          busy_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  logic [15:0]   rd_data_i,
  output logic          result_strobe_o,
  output fcw_out_t      result_o
);

  // Limits beyond which a lookup falls outside the store
  localparam logic [28:0] Lim12 = 29'(2 * Words - 1);
  localparam logic [27:0] Lim16 = 28'(Words);
  localparam logic [27:0] Lim32 = 28'(Words / 2);

  fcw_state_e    state_q, state_d;
  logic          strobe_q, strobe_d;
  fcw_out_t      result_q, result_d;
  logic [27:0]   clust_q;
  logic [15:0]   hops_q;
  logic [15:0]   done_q;
  logic [AW-1:0] addr_q;
  logic          two_q;
  logic          b_odd_q;
  logic [15:0]   word0_q;

  logic [28:0]   byte_off;
  logic          look_oor;
  logic [AW-1:0] look_addr;
  logic          look_two;
  logic [15:0]   lo_word;
  logic [27:0]   entry;
  logic          entry_stop;
  logic [15:0]   done_inc;
  logic          last_hop;
  logic          eval_now;
  logic          eval_finish;
  logic          take_walk;
  logic          take_load;

  assign take_load = accept_i && (item_i.func == FUNC_LOAD);
  assign take_walk = accept_i && (item_i.func == FUNC_WALK);

  // Entry location for the current cluster
  assign byte_off = {1'b0, clust_q} + {2'b00, clust_q[27:1]};

  always_comb begin
    unique case (mode_i)
      FCW_FAT12: begin
        look_oor  = (byte_off >= Lim12);
        look_addr = AW'(byte_off[28:1]);
        look_two  = byte_off[0];
      end
      FCW_FAT16: begin
        look_oor  = (clust_q >= Lim16);
        look_addr = AW'(clust_q);
        look_two  = 1'b0;
      end
      default: begin
        look_oor  = (clust_q >= Lim32);
        look_addr = AW'({clust_q, 1'b0});
        look_two  = 1'b1;
      end
    endcase
  end

  // Decode the entry once its words are in
  assign lo_word     = (state_q == ST_RD1) ? word0_q : rd_data_i;
  assign entry       = fcw_entry(mode_i, clust_q[0], b_odd_q, lo_word, rd_data_i);
  assign entry_stop  = fcw_stop(mode_i, entry);
  assign done_inc    = done_q + 16'd1;
  assign last_hop    = (done_inc == hops_q);
  assign eval_now    = ((state_q == ST_RD0) && !two_q) || (state_q == ST_RD1);
  assign eval_finish = eval_now && (entry_stop || last_hop);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take_walk && (item_i.hop_count != 16'd0)) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: state_d = look_oor ? ST_IDLE : ST_RD0;
      ST_RD0: begin
        if (two_q) begin
          state_d = ST_RD1;
        end else begin
          state_d = eval_finish ? ST_IDLE : ST_LOOK;
        end
      end
      ST_RD1:  state_d = eval_finish ? ST_IDLE : ST_LOOK;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs: busy flag and read port
  always_comb begin
    busy_o    = 1'b1;
    rd_en_o   = 1'b0;
    rd_addr_o = addr_q + AW'(1);
    unique case (state_q)
      ST_IDLE: busy_o = 1'b0;
      ST_LOOK: begin
        rd_en_o   = !look_oor;
        rd_addr_o = look_addr;
      end
      ST_RD0:  rd_en_o = two_q;
      ST_RD1:  rd_en_o = 1'b0;
      default: busy_o = 1'b0;
    endcase
  end

  // Result to present in the next cycle
  always_comb begin
    strobe_d = 1'b0;
    result_d = '0;
    if (take_load) begin
      strobe_d = 1'b1;
    end else if (take_walk && (item_i.hop_count == 16'd0)) begin
      strobe_d                 = 1'b1;
      result_d.reached_cluster = {4'h0, item_i.start_cluster};
    end else if ((state_q == ST_LOOK) && look_oor) begin
      strobe_d              = 1'b1;
      result_d.out_of_range = 1'b1;
      result_d.hops_done    = done_q;
    end else if (eval_finish) begin
      strobe_d = 1'b1;
      if (entry_stop) begin
        result_d.chain_ended = 1'b1;
        result_d.hops_done   = done_q;
      end else begin
        result_d.reached_cluster = {4'h0, entry};
        result_d.hops_done       = done_inc;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  // Walk datapath registers
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    if ((state_q == ST_IDLE) && take_walk) begin
      clust_q <= item_i.start_cluster;
      hops_q  <= item_i.hop_count;
      done_q  <= 16'd0;
    end
    if (state_q == ST_LOOK) begin
      addr_q  <= look_addr;
      two_q   <= look_two;
      b_odd_q <= byte_off[0];
    end
    if ((state_q == ST_RD0) && two_q) begin
      word0_q <= rd_data_i;
    end
    // Advance one link
    if (eval_now && !eval_finish) begin
      clust_q <= entry;
      done_q  <= done_inc;
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

endmodule

`default_nettype wire

FILE: test/fat_cluster_chain_walker_top_tb.sv
// Testbench for fat_cluster_chain_walker_top: loads table words and walks cluster chains
// under every entry width. Depends on fcw_pkg and the RTL of the block only.
`default_nettype none

module fat_cluster_chain_walker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcw_pkg::*;

  localparam int unsigned FAT_WORDS   = 32768;
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          WALK_BUDGET = 64;
  localparam int          PHASE_ITEMS = 55;
  // code three of the mode register behaves as FAT32
  localparam logic [1:0]  MODE_FAT32_ALIAS = 2'd3;

  typedef enum int {LK_HIT, LK_BEYOND, LK_UNWRITTEN} lookup_e;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  fcw_in_t    item_i;
  logic       result_strobe_o;
  fcw_out_t   result_o;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;

  // predictor copy of the table and of the mode register
  bit [15:0]  fat_mem     [FAT_WORDS];
  bit         fat_written [FAT_WORDS];
  logic [1:0] width_mode;

  fcw_out_t    due_results [$];
  fcw_out_t    oldest;
  logic [27:0] chain_heads [$];
  logic [27:0] chain_links [$];
  bit          no_gaps;
  int          err_cnt;
  int          cycle_cnt;

  fat_cluster_chain_walker_top #(
    .FAT_WORDS(FAT_WORDS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Fetch the table entry of cluster n under the current width
  function automatic lookup_e entry_lookup(input logic [27:0] n, output logic [27:0] val,
                                           output logic [27:0] end_mark);
    longint     b;
    logic [7:0] lo_b;
    logic [7:0] hi_b;
    logic [15:0] pair;
    val      = '0;
    end_mark = '0;
    case (width_mode)
      FCW_FAT12: begin
        b = longint'(n) + longint'(n) / 2;
        if (b + 1 >= 2 * FAT_WORDS) return LK_BEYOND;
        if (!fat_written[b >> 1] || !fat_written[(b + 1) >> 1]) return LK_UNWRITTEN;
        lo_b = b[0] ? fat_mem[b >> 1][15:8] : fat_mem[b >> 1][7:0];
        hi_b = b[0] ? fat_mem[(b + 1) >> 1][7:0] : fat_mem[(b + 1) >> 1][15:8];
        pair = {hi_b, lo_b};
        val  = n[0] ? 28'(pair[15:4]) : 28'(pair[11:0]);
        end_mark = FCW_END12;
      end
      FCW_FAT16: begin
        if (n >= FAT_WORDS) return LK_BEYOND;
        if (!fat_written[n]) return LK_UNWRITTEN;
        val      = 28'(fat_mem[n]);
        end_mark = FCW_END16;
      end
      default: begin
        b = longint'(n) * 2;
        if (b + 1 >= FAT_WORDS) return LK_BEYOND;
        if (!fat_written[b] || !fat_written[b + 1]) return LK_UNWRITTEN;
        val      = {fat_mem[b + 1][11:0], fat_mem[b]};
        end_mark = FCW_END32;
      end
    endcase
    return LK_HIT;
  endfunction

  // Follow the chain; cut_at gives the hop at which an unwritten entry would be read
  function automatic void follow_chain(input logic [27:0] first, input int hops,
                                       output fcw_out_t res, output int cut_at);
    logic [27:0] clust;
    logic [27:0] nxt;
    logic [27:0] end_mark;
    int          done;
    bit          ended;
    bit          beyond;
    lookup_e     st;
    clust  = first;
    done   = 0;
    ended  = 1'b0;
    beyond = 1'b0;
    cut_at = -1;
    while (done < hops && !ended && !beyond && cut_at < 0) begin
      st = entry_lookup(clust, nxt, end_mark);
      if (st == LK_BEYOND) beyond = 1'b1;
      else if (st == LK_UNWRITTEN) cut_at = done;
      else if (nxt == '0 || nxt >= end_mark) ended = 1'b1;
      else begin
        clust = nxt;
        done++;
      end
    end
    res.reached_cluster = (ended || beyond) ? 32'd0 : {4'd0, clust};
    res.chain_ended     = ended;
    res.hops_done       = 16'(done);
    res.out_of_range    = beyond;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Compare every strobed result with the oldest outstanding prediction
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (due_results.size() == 0) begin
        $error("result strobed with no transfer outstanding");
        err_cnt++;
      end else begin
        oldest = due_results.pop_front();
        report_field("reached_cluster", oldest.reached_cluster, result_o.reached_cluster);
        report_field("chain_ended", 32'(oldest.chain_ended), 32'(result_o.chain_ended));
        report_field("hops_done", 32'(oldest.hops_done), 32'(result_o.hops_done));
        report_field("out_of_range", 32'(oldest.out_of_range), 32'(result_o.out_of_range));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[fat_cluster_chain_walker_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until the transfer, then record its expected result
  task automatic send_item(input fcw_in_t it);
    fcw_out_t res;
    int       cut;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    if (it.func == FUNC_LOAD) begin
      fat_mem[it.load_index]     = it.load_word;
      fat_written[it.load_index] = 1'b1;
      res = '0;
    end else begin
      follow_chain(it.start_cluster, int'(it.hop_count), res, cut);
    end
    due_results.push_back(res);
  endtask

  // Mostly short gaps, a few long ones
  task automatic idle_gap();
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) g = 0;
    else if (r < 90) g = $urandom_range(1, 3);
    else g = $urandom_range(8, 40);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // Write the mode register while the block is idle
  task automatic set_mode(input logic [1:0] m);
    drain();
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    width_mode  = m;
  endtask

  task automatic send_load(input logic [14:0] idx, input logic [15:0] word);
    fcw_in_t it;
    it.func          = FUNC_LOAD;
    it.load_index    = idx;
    it.load_word     = word;
    it.start_cluster = 28'($urandom());
    it.hop_count     = 16'($urandom());
    send_item(it);
    idle_gap();
  endtask

  // Trim the hop count so that no unwritten entry is read and loops stay short
  task automatic send_walk(input logic [27:0] first, input int hops, input int max_hops);
    fcw_in_t  it;
    fcw_out_t res;
    int       cut;
    follow_chain(first, hops, res, cut);
    if (cut >= 0) hops = cut;
    if (res.hops_done > max_hops) hops = $urandom_range(0, max_hops);
    it.func          = FUNC_WALK;
    it.load_index    = 15'($urandom());
    it.load_word     = 16'($urandom());
    it.start_cluster = first;
    it.hop_count     = 16'(hops);
    send_item(it);
    idle_gap();
  endtask

  // Write entry n under the current width through word loads
  task automatic set_entry(input logic [27:0] n, input logic [31:0] val);
    longint     b;
    longint     w0;
    longint     w1;
    logic [7:0] b0;
    logic [7:0] b1;
    case (width_mode)
      FCW_FAT12: begin
        b  = longint'(n) + longint'(n) / 2;
        w0 = b >> 1;
        w1 = (b + 1) >> 1;
        b0 = b[0] ? fat_mem[w0][15:8] : fat_mem[w0][7:0];
        b1 = b[0] ? fat_mem[w1][7:0] : fat_mem[w0][15:8];
        if (n[0]) begin
          b0 = {val[3:0], b0[3:0]};
          b1 = val[11:4];
        end else begin
          b0 = val[7:0];
          b1 = {b1[7:4], val[11:8]};
        end
        if (!b[0]) begin
          send_load(15'(w0), {b1, b0});
        end else begin
          send_load(15'(w0), {b0, fat_mem[w0][7:0]});
          send_load(15'(w1), {fat_mem[w1][15:8], b1});
        end
      end
      FCW_FAT16: send_load(15'(n), val[15:0]);
      default: begin
        send_load(15'(longint'(n) * 2), val[15:0]);
        send_load(15'(longint'(n) * 2 + 1), val[31:16]);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // FAT12 straight out of reset, including the top of the store
  task automatic test_fat12_from_reset();
    send_load(15'd0, 16'h0000);
    send_load(15'h7fff, 16'hffff);
    set_entry(28'd2, 32'd3);
    set_entry(28'd3, 32'h0fff);
    send_walk(28'd2, 0, 65535);
    send_walk(28'd2, 1, 65535);
    send_walk(28'd2, 5, 65535);
    set_entry(28'd43689, 32'd2);
    send_walk(28'd43689, 3, 65535);
    send_walk(28'd43690, 1, 65535);
    send_walk(28'h0ffffff, 0, 65535);
  endtask

  // FAT16: longest walk on a self loop, free entry, markers, link past the store
  task automatic test_fat16_links();
    set_mode(FCW_FAT16);
    set_entry(28'd5, 32'd5);
    send_walk(28'd5, 65535, 65535);
    set_entry(28'd32767, 32'h8000);
    send_walk(28'd32767, 2, 65535);
    set_entry(28'd6, 32'd7);
    set_entry(28'd7, 32'd0);
    send_walk(28'd6, 3, 65535);
    set_entry(28'd8, 32'd1);
    send_walk(28'd8, 1, 65535);
    set_entry(28'd9, 32'hfff8);
    send_walk(28'd9, 1, 65535);
    set_entry(28'd10, 32'hfff7);
    send_walk(28'd10, 1, 65535);
  endtask

  // FAT32: reserved top bits masked, marker edges, link past the store
  task automatic test_fat32_links();
    set_mode(FCW_FAT32);
    set_entry(28'd16383, 32'hf000_0005);
    send_walk(28'd16383, 1, 65535);
    send_walk(28'd16384, 1, 65535);
    set_entry(28'd20, 32'hffff_fff8);
    send_walk(28'd20, 1, 65535);
    set_entry(28'd21, 32'h0fff_fff7);
    send_walk(28'd21, 2, 65535);
  endtask

  // Mode code three walks as FAT32
  task automatic test_mode_three();
    set_mode(MODE_FAT32_ALIAS);
    send_walk(28'd20, 1, 65535);
    send_walk(28'd21, 2, 65535);
    send_walk(28'd16384, 1, 65535);
  endtask

  function automatic logic [31:0] end_marker();
    case (width_mode)
      FCW_FAT12: return 32'($urandom_range(32'hff8, 32'hfff));
      FCW_FAT16: return 32'($urandom_range(32'hfff8, 32'hffff));
      default:   return {4'($urandom()), 28'($urandom_range(32'hffffff8, 32'hfffffff))};
    endcase
  endfunction

  // Lay down short chains with assorted endings
  task automatic build_chains(input int count);
    logic [27:0] links [$];
    logic [31:0] tail;
    int          len;
    int          kind;
    for (int c = 0; c < count; c++) begin
      links.delete();
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if (i == 0 && $urandom_range(0, 9) == 0) begin
          case (width_mode)
            FCW_FAT12: links.push_back(28'($urandom_range(43000, 43689)));
            FCW_FAT16: links.push_back(28'($urandom_range(31000, 32767)));
            default:   links.push_back(28'($urandom_range(15000, 16383)));
          endcase
        end else begin
          links.push_back(28'($urandom_range(2, 1500)));
        end
      end
      for (int i = 0; i + 1 < len; i++)
        set_entry(links[i], {4'($urandom()), links[i + 1]});
      kind = $urandom_range(0, 9);
      if (kind < 4) tail = end_marker();
      else if (kind < 6) tail = 32'd0;
      else if (kind < 8) tail = {4'($urandom()), links[0]};
      else if (kind == 8 && width_mode == FCW_FAT16) tail = $urandom_range(32768, 32'hfff7);
      else if (kind == 8 && width_mode != FCW_FAT12)
        tail = {4'($urandom()), 28'($urandom_range(16384, 32'hffffff7))};
      else tail = 32'd1;
      set_entry(links[len - 1], tail);
      chain_heads.push_back(links[0]);
      foreach (links[i]) chain_links.push_back(links[i]);
    end
  endtask

  // Mostly walks along built chains, with stray loads and wild starts mixed in
  task automatic test_random_traffic();
    logic [1:0] phase_modes [6];
    int         r;
    int         hops;
    phase_modes = '{FCW_FAT16, FCW_FAT32, FCW_FAT12, MODE_FAT32_ALIAS,
                    2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
    foreach (phase_modes[p]) begin
      set_mode(phase_modes[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      chain_heads.delete();
      chain_links.delete();
      build_chains(4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain();
        r    = $urandom_range(0, 99);
        hops = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 10);
        if (r < 55)
          send_walk(chain_heads[$urandom_range(0, chain_heads.size() - 1)], hops, WALK_BUDGET);
        else if (r < 70)
          send_walk(chain_links[$urandom_range(0, chain_links.size() - 1)], hops, WALK_BUDGET);
        else if (r < 80)
          send_load(15'($urandom()), 16'($urandom()));
        else if (r < 90)
          send_walk(28'($urandom()), $urandom_range(0, 65535), WALK_BUDGET);
        else
          send_walk(28'($urandom_range(0, 1500)), hops, WALK_BUDGET);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    width_mode  = FCW_FAT12;
    no_gaps     = 1'b0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fat12_from_reset();
    test_fat16_links();
    test_fat32_links();
    test_mode_three();
    test_random_traffic();

    // let the last transfers land, then look for strays
    drain();
    repeat (10) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("[fat_cluster_chain_walker_top] OK");
    end else begin
      $display("[fat_cluster_chain_walker_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: fat_cluster_chain_walker_top.f
+incdir+design
design/fcw_pkg.sv
design/fcw_table_mem.sv
design/fcw_walker.sv
design/fat_cluster_chain_walker_top.sv
test/fat_cluster_chain_walker_top_tb.sv
